@@ hdl/alt_pkg.sv @@
// Package for the array list table: sizes, codes, item and state types.
package alt_pkg;

	// Store depth and derived widths
	localparam int CAPACITY = 128;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CMP_W    = (CNT_W > 8) ? CNT_W : 8;

	// Request kinds
	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_DELETE = 2'd1,
		KIND_READ   = 2'd2,
		KIND_FIND   = 2'd3
	} kind_t;

	// Result status codes
	typedef enum logic [2:0] {
		STAT_OK       = 3'd0,
		STAT_FULL     = 3'd1,
		STAT_BADPOS   = 3'd2,
		STAT_EMPTY    = 3'd3,
		STAT_NOTFOUND = 3'd4
	} status_t;

	// Request item
	typedef struct packed {
		kind_t              kind;
		logic [7:0]         position;
		logic signed [31:0] value;
	} req_item_t;

	// Result item
	typedef struct packed {
		status_t            status;
		logic signed [31:0] read_value;
		logic [7:0]         found_position;
		logic [7:0]         length;
	} rsp_item_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS,
		ST_INS_LAST,
		ST_DEL,
		ST_READ,
		ST_FIND,
		ST_RESP
	} state_t;

endpackage

@@ hdl/array_list_table_unit.sv @@
// Array list table: ordered list of signed values in a single-port-pair memory.
//
// Requests enter on req (valid/ready) and one result per request leaves on rsp
// (valid/ready). Each request is insert, delete, read-at or find; the result
// carries a status, the read value, the found position and the list length.
// One request is worked on at a time; req_ready is high while the sequencer
// is idle, also while an earlier result still waits in the output register.
// Read fetches entry p; insert shifts entries p..L (L the length) up, then
// writes (append or empty list: at once); delete shifts entries after p down
// (tail removal just shortens); find walks from the head to a match or the tail.
// The cost is set by the memory: one read and one write per cycle, so a
// shift or a search moves one entry per cycle; errors go straight to the result.
// Reset clears the length and the control state; memory contents need no
// clearing since only entries below the length are ever read.
// When the receiver stalls the finished result holds in the output register,
// the next request may still be accepted, and its result waits in the
// sequencer until the output register frees.
module array_list_table_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  alt_pkg::req_item_t  req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output alt_pkg::rsp_item_t  rsp
);

	// List store
	logic signed [31:0] mem [alt_pkg::CAPACITY];
	logic signed [31:0] rdata_q;

	// Memory port controls
	logic                     mem_we;
	logic                     mem_re;
	logic [alt_pkg::CMP_W-1:0] mem_wa;
	logic [alt_pkg::CMP_W-1:0] mem_ra;
	logic signed [31:0]       mem_wd;

	// Control state
	alt_pkg::state_t           state_q, state_d;
	logic [alt_pkg::CNT_W-1:0] count_q, count_d;
	logic                      rsp_valid_q;
	alt_pkg::rsp_item_t        rsp_q;

	// Request and result registers
	logic [alt_pkg::CMP_W-1:0] pos_q;
	logic signed [31:0]        val_q;
	logic [alt_pkg::CMP_W-1:0] rp_q;
	alt_pkg::status_t          res_status_q;
	logic signed [31:0]        res_rd_q;
	logic [7:0]                res_fpos_q;

	// Decode helpers
	logic [alt_pkg::CMP_W-1:0] pos_w;
	logic [alt_pkg::CMP_W-1:0] cnt_w;
	logic                      is_empty;
	logic                      is_full;
	logic                      ins_bad;
	logic                      ins_append;
	logic                      ins_shift;
	logic                      pos_inrange;
	logic                      del_shift;
	logic                      at_tail;
	logic                      ins_last;
	logic                      match;
	logic                      slot_free;
	logic                      accept;
	logic [alt_pkg::CMP_W-1:0] fpos_w;

	assign pos_w       = alt_pkg::CMP_W'(req.position);
	assign cnt_w       = alt_pkg::CMP_W'(count_q);
	assign is_empty    = (count_q == '0);
	assign is_full     = (cnt_w >= alt_pkg::CMP_W'(alt_pkg::CAPACITY));
	assign ins_bad     = (pos_w == '0) || (pos_w > cnt_w + 1'b1);
	assign ins_append  = !is_full && !is_empty && (pos_w == cnt_w + 1'b1);
	assign ins_shift   = !is_full && !is_empty && !ins_bad && !ins_append;
	assign pos_inrange = (pos_w != '0) && (pos_w <= cnt_w);
	assign del_shift   = !is_empty && pos_inrange && (pos_w != cnt_w);
	assign at_tail     = (rp_q == cnt_w - 1'b1);
	assign ins_last    = (rp_q == pos_q - 1'b1);
	assign match       = (rdata_q == val_q);
	assign slot_free   = !rsp_valid_q || rsp_ready;
	assign req_ready   = (state_q == alt_pkg::ST_IDLE);
	assign accept      = req_valid && req_ready;
	assign fpos_w      = rp_q + 1'b1;
	assign rsp_valid   = rsp_valid_q;
	assign rsp         = rsp_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			alt_pkg::ST_IDLE: begin
				if (req_valid) begin
					unique case (req.kind)
						alt_pkg::KIND_INSERT:
							state_d = ins_shift ? alt_pkg::ST_INS : alt_pkg::ST_RESP;
						alt_pkg::KIND_DELETE:
							state_d = del_shift ? alt_pkg::ST_DEL : alt_pkg::ST_RESP;
						alt_pkg::KIND_READ:
							state_d = (!is_empty && pos_inrange) ? alt_pkg::ST_READ
								: alt_pkg::ST_RESP;
						alt_pkg::KIND_FIND:
							state_d = is_empty ? alt_pkg::ST_RESP : alt_pkg::ST_FIND;
						default: state_d = alt_pkg::ST_RESP;
					endcase
				end
			end
			alt_pkg::ST_INS: begin
				if (ins_last) state_d = alt_pkg::ST_INS_LAST;
			end
			alt_pkg::ST_INS_LAST: state_d = alt_pkg::ST_RESP;
			alt_pkg::ST_DEL: begin
				if (at_tail) state_d = alt_pkg::ST_RESP;
			end
			alt_pkg::ST_READ: state_d = alt_pkg::ST_RESP;
			alt_pkg::ST_FIND: begin
				if (match || at_tail) state_d = alt_pkg::ST_RESP;
			end
			alt_pkg::ST_RESP: begin
				if (slot_free) state_d = alt_pkg::ST_IDLE;
			end
			default: state_d = alt_pkg::ST_IDLE;
		endcase
	end

	// Memory ports and length update
	always_comb begin
		mem_we  = 1'b0;
		mem_re  = 1'b0;
		mem_wa  = '0;
		mem_ra  = '0;
		mem_wd  = rdata_q;
		count_d = count_q;
		unique case (state_q)
			alt_pkg::ST_IDLE: begin
				if (req_valid) begin
					unique case (req.kind)
						alt_pkg::KIND_INSERT: begin
							if (!is_full && is_empty) begin
								mem_we  = 1'b1;
								mem_wa  = '0;
								mem_wd  = req.value;
								count_d = count_q + 1'b1;
							end else if (ins_append) begin
								mem_we  = 1'b1;
								mem_wa  = cnt_w;
								mem_wd  = req.value;
								count_d = count_q + 1'b1;
							end else if (ins_shift) begin
								mem_re = 1'b1;
								mem_ra = cnt_w - 1'b1;
							end
						end
						alt_pkg::KIND_DELETE: begin
							if (del_shift) begin
								mem_re = 1'b1;
								mem_ra = pos_w;
							end else if (!is_empty && pos_inrange) begin
								count_d = count_q - 1'b1;
							end
						end
						alt_pkg::KIND_READ: begin
							if (!is_empty && pos_inrange) begin
								mem_re = 1'b1;
								mem_ra = pos_w - 1'b1;
							end
						end
						alt_pkg::KIND_FIND: begin
							mem_re = !is_empty;
							mem_ra = '0;
						end
						default: mem_re = 1'b0;
					endcase
				end
			end
			alt_pkg::ST_INS: begin
				mem_we = 1'b1;
				mem_wa = rp_q + 1'b1;
				if (!ins_last) begin
					mem_re = 1'b1;
					mem_ra = rp_q - 1'b1;
				end
			end
			alt_pkg::ST_INS_LAST: begin
				mem_we  = 1'b1;
				mem_wa  = pos_q - 1'b1;
				mem_wd  = val_q;
				count_d = count_q + 1'b1;
			end
			alt_pkg::ST_DEL: begin
				mem_we = 1'b1;
				mem_wa = rp_q - 1'b1;
				if (at_tail) begin
					count_d = count_q - 1'b1;
				end else begin
					mem_re = 1'b1;
					mem_ra = rp_q + 1'b1;
				end
			end
			alt_pkg::ST_FIND: begin
				if (!match && !at_tail) begin
					mem_re = 1'b1;
					mem_ra = rp_q + 1'b1;
				end
			end
			default: mem_we = 1'b0;
		endcase
	end

	// Store write and registered read
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa[alt_pkg::IDX_W-1:0]] <= mem_wd;
		if (mem_re) rdata_q <= mem[mem_ra[alt_pkg::IDX_W-1:0]];
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= alt_pkg::ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (state_q == alt_pkg::ST_RESP && slot_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Request capture, walk pointer and result
	always_ff @(posedge clk) begin
		case (state_q)
			alt_pkg::ST_IDLE: begin
				if (accept) begin
					pos_q      <= pos_w;
					val_q      <= req.value;
					res_rd_q   <= '0;
					res_fpos_q <= '0;
					rp_q       <= '0;
					res_status_q <= alt_pkg::STAT_OK;
					case (req.kind)
						alt_pkg::KIND_INSERT: begin
							rp_q <= cnt_w - 1'b1;
							if (is_full) res_status_q <= alt_pkg::STAT_FULL;
							else if (!is_empty && ins_bad) res_status_q <= alt_pkg::STAT_BADPOS;
						end
						alt_pkg::KIND_DELETE, alt_pkg::KIND_READ: begin
							rp_q <= pos_w;
							if (is_empty) res_status_q <= alt_pkg::STAT_EMPTY;
							else if (!pos_inrange) res_status_q <= alt_pkg::STAT_BADPOS;
						end
						default: begin
							if (is_empty) res_status_q <= alt_pkg::STAT_EMPTY;
						end
					endcase
				end
			end
			alt_pkg::ST_INS: rp_q <= rp_q - 1'b1;
			alt_pkg::ST_DEL: rp_q <= rp_q + 1'b1;
			alt_pkg::ST_READ: res_rd_q <= rdata_q;
			alt_pkg::ST_FIND: begin
				rp_q <= rp_q + 1'b1;
				if (match) begin
					res_fpos_q <= fpos_w[7:0];
				end else if (at_tail) begin
					res_status_q <= alt_pkg::STAT_NOTFOUND;
				end
			end
			alt_pkg::ST_RESP: begin
				if (slot_free) begin
					rsp_q.status         <= res_status_q;
					rsp_q.read_value     <= res_rd_q;
					rsp_q.found_position <= res_fpos_q;
					rsp_q.length         <= cnt_w[7:0];
				end
			end
			default: rp_q <= rp_q;
		endcase
	end

	// Length never exceeds the store
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_w <= alt_pkg::CMP_W'(alt_pkg::CAPACITY))
		else $error("list length above capacity");

	// Read and write never hit the same entry in one cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && mem_re) |-> (mem_wa != mem_ra))
		else $error("read and write collide on one entry");

	// A loaded result reports the length left by its request
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == alt_pkg::ST_RESP && slot_free) |=> (rsp_valid && rsp.length == cnt_w[7:0]))
		else $error("result length differs from list length");

	// Requests are taken only when no walk is under way
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ($past(state_q) == alt_pkg::ST_IDLE && state_q != alt_pkg::ST_INS_LAST))
		else $error("request accepted outside idle");

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the array list table unit: stimulus, prediction and checking.
`timescale 1ns / 100ps

module tb;

	localparam int RAND_ITEMS = 950;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_ready;
	alt_pkg::req_item_t req       = '0;
	logic               rsp_valid;
	logic               rsp_ready = 1'b0;
	alt_pkg::rsp_item_t rsp;

	array_list_table_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// Shadow list held by the predictor
	logic signed [31:0] list_mem [alt_pkg::CAPACITY];
	int                 list_len = 0;

	// Request items waiting to be driven, results awaited
	alt_pkg::req_item_t req_backlog [$];
	alt_pkg::rsp_item_t awaited_rsp [$];

	int n_queued    = 0;
	int n_accepted  = 0;
	int n_rand      = 0;
	int gen_len     = 0;
	int bad_results = 0;

	int tx_gap   = 0;
	int tx_quiet = 0;
	int rx_hold  = 0;
	int rx_quiet = 0;

	// Apply one request to the shadow list and return the result it must give
	function automatic alt_pkg::rsp_item_t apply_request(alt_pkg::req_item_t r);
		alt_pkg::rsp_item_t res;
		int                 p;
		int                 j;
		bit                 hit;
		res        = '0;
		res.status = alt_pkg::STAT_OK;
		p          = int'(r.position);
		hit        = 1'b0;
		case (r.kind)
			alt_pkg::KIND_INSERT: begin
				if (list_len >= alt_pkg::CAPACITY) begin
					res.status = alt_pkg::STAT_FULL;
				end else if (list_len == 0) begin
					list_mem[0] = r.value;
					list_len    = 1;
				end else if (p < 1 || p > list_len + 1) begin
					res.status = alt_pkg::STAT_BADPOS;
				end else begin
					for (j = list_len; j >= p; j--)
						list_mem[j] = list_mem[j - 1];
					list_mem[p - 1] = r.value;
					list_len++;
				end
			end
			alt_pkg::KIND_DELETE: begin
				if (list_len == 0) begin
					res.status = alt_pkg::STAT_EMPTY;
				end else if (p < 1 || p > list_len) begin
					res.status = alt_pkg::STAT_BADPOS;
				end else begin
					for (j = p - 1; j + 1 < list_len; j++)
						list_mem[j] = list_mem[j + 1];
					list_len--;
				end
			end
			alt_pkg::KIND_READ: begin
				if (list_len == 0)
					res.status = alt_pkg::STAT_EMPTY;
				else if (p < 1 || p > list_len)
					res.status = alt_pkg::STAT_BADPOS;
				else
					res.read_value = list_mem[p - 1];
			end
			default: begin
				if (list_len == 0) begin
					res.status = alt_pkg::STAT_EMPTY;
				end else begin
					res.status = alt_pkg::STAT_NOTFOUND;
					for (j = 0; j < list_len; j++) begin
						if (!hit && list_mem[j] == r.value) begin
							hit                = 1'b1;
							res.found_position = 8'(j + 1);
							res.status         = alt_pkg::STAT_OK;
						end
					end
				end
			end
		endcase
		res.length = 8'(list_len);
		return res;
	endfunction

	// Idle length: mostly short, a few long, with stretches of none at all
	function automatic int pick_gap(inout int quiet);
		int r;
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		if ($urandom_range(0, 29) == 0) begin
			quiet = $urandom_range(15, 50);
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Queue one request item and track the list length it leaves behind
	task automatic queue_req(alt_pkg::kind_t k, int pos, logic signed [31:0] v);
		alt_pkg::req_item_t it;
		it.kind     = k;
		it.position = 8'(pos);
		it.value    = v;
		req_backlog.push_back(it);
		n_queued++;
		case (k)
			alt_pkg::KIND_INSERT:
				if (gen_len < alt_pkg::CAPACITY && (gen_len == 0 ||
						(it.position >= 1 && it.position <= gen_len + 1)))
					gen_len++;
			alt_pkg::KIND_DELETE:
				if (gen_len > 0 && it.position >= 1 && it.position <= gen_len)
					gen_len--;
			default: ;
		endcase
	endtask

	// Values from a small pool so that finds hit, plus full range and extremes
	function automatic logic signed [31:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return int'($urandom_range(0, 31)) - 16;
		if (r < 85)
			return $urandom;
		case ($urandom_range(0, 3))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7fff_ffff;
			2:       return 32'sd0;
			default: return -32'sd1;
		endcase
	endfunction

	// Random request weighted by insert and delete percentages
	task automatic gen_random(int ins_pct, int del_pct);
		int                 r;
		int                 top;
		int                 pos;
		alt_pkg::kind_t     k;
		logic signed [31:0] v;
		r = $urandom_range(0, 99);
		if (r < ins_pct)
			k = alt_pkg::KIND_INSERT;
		else if (r < ins_pct + del_pct)
			k = alt_pkg::KIND_DELETE;
		else if ($urandom_range(0, 1) == 0)
			k = alt_pkg::KIND_READ;
		else
			k = alt_pkg::KIND_FIND;
		top = (k == alt_pkg::KIND_INSERT) ? gen_len + 1 : gen_len;
		if (top == 0 || $urandom_range(0, 9) == 0) begin
			case ($urandom_range(0, 2))
				0:       pos = 0;
				1:       pos = top + 1;
				default: pos = $urandom_range(0, 255);
			endcase
		end else begin
			pos = $urandom_range(1, top);
		end
		if (k == alt_pkg::KIND_INSERT || k == alt_pkg::KIND_FIND)
			v = pick_value();
		else
			v = $urandom;
		queue_req(k, pos, v);
		n_rand++;
	endtask

	// Compare one result item with the oldest one awaited
	task automatic check_rsp(alt_pkg::rsp_item_t got);
		alt_pkg::rsp_item_t want;
		if (awaited_rsp.size() == 0) begin
			bad_results++;
			if (bad_results <= 10)
				$display("unexpected result: status %0d read %0d found %0d length %0d",
					got.status, got.read_value, got.found_position, got.length);
		end else begin
			want = awaited_rsp.pop_front();
			if (got.status !== want.status || got.read_value !== want.read_value ||
					got.found_position !== want.found_position ||
					got.length !== want.length) begin
				bad_results++;
				if (bad_results <= 10) begin
					$display("result mismatch: expected status %0d read %0d found %0d length %0d",
						want.status, want.read_value, want.found_position, want.length);
					$display("                 got      status %0d read %0d found %0d length %0d",
						got.status, got.read_value, got.found_position, got.length);
				end
			end
		end
	endtask

	// Clock
	initial begin
		forever #5 clk = ~clk;
	end

	// Driver: predict each accepted item, then present the next after its gap
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && req_ready) begin
				awaited_rsp.push_back(apply_request(req));
				n_accepted++;
				tx_gap = pick_gap(tx_quiet);
			end
			if (!req_valid || req_ready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					req_valid <= 1'b0;
				end else if (req_backlog.size() > 0) begin
					req       <= req_backlog.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check accepted results, stall the result side at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready)
				check_rsp(rsp);
			if (rx_hold > 0) begin
				rx_hold--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
				if ((rsp_valid && rsp_ready) || $urandom_range(0, 15) == 0)
					rx_hold = pick_gap(rx_quiet);
			end
		end
	end

	// Stimulus, reset and end of run
	initial begin
		// Empty list: delete, read and find report empty
		queue_req(alt_pkg::KIND_READ, 1, 32'sd7);
		queue_req(alt_pkg::KIND_DELETE, 0, 32'sd0);
		queue_req(alt_pkg::KIND_FIND, 1, 32'sd0);
		// Insert into empty list lands at the head whatever the position
		queue_req(alt_pkg::KIND_INSERT, 0, 32'sh7fff_ffff);
		queue_req(alt_pkg::KIND_INSERT, 0, 32'sd1);
		queue_req(alt_pkg::KIND_INSERT, 3, 32'sd2);
		queue_req(alt_pkg::KIND_INSERT, 1, 32'sh8000_0000);
		queue_req(alt_pkg::KIND_INSERT, 3, 32'sd0);
		queue_req(alt_pkg::KIND_INSERT, 2, -32'sd1);
		// Reads out of range and at both ends
		queue_req(alt_pkg::KIND_READ, 0, 32'sd0);
		queue_req(alt_pkg::KIND_READ, 5, 32'sd0);
		queue_req(alt_pkg::KIND_READ, 1, 32'sd0);
		queue_req(alt_pkg::KIND_READ, 4, 32'sd0);
		// Finds with and without a match
		queue_req(alt_pkg::KIND_FIND, 0, -32'sd1);
		queue_req(alt_pkg::KIND_FIND, 255, 32'sh7fff_ffff);
		queue_req(alt_pkg::KIND_FIND, 1, 32'sd12345);
		// Deletes out of range, at the tail and at the head
		queue_req(alt_pkg::KIND_DELETE, 0, 32'sd0);
		queue_req(alt_pkg::KIND_DELETE, 5, 32'sd0);
		queue_req(alt_pkg::KIND_DELETE, 4, 32'sd0);
		queue_req(alt_pkg::KIND_DELETE, 1, 32'sd0);
		queue_req(alt_pkg::KIND_DELETE, 1, 32'sd0);
		queue_req(alt_pkg::KIND_DELETE, 1, 32'sd0);
		queue_req(alt_pkg::KIND_INSERT, 255, 32'sh5555_aaaa);
		queue_req(alt_pkg::KIND_READ, 1, 32'sd0);

		// Swing the list between empty and full, mixing in noise
		while (n_rand < RAND_ITEMS) begin
			while (gen_len < alt_pkg::CAPACITY && n_rand < RAND_ITEMS)
				gen_random(85, 5);
			repeat (12) gen_random(60, 10);
			while (gen_len > 0 && n_rand < RAND_ITEMS)
				gen_random(8, 82);
			repeat (80) gen_random(40, 35);
		end

		// Hold reset, then release away from the active edge
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Drain: every item accepted, every result in, then settle
		while (n_accepted < n_queued) @(negedge clk);
		while (awaited_rsp.size() != 0) @(negedge clk);
		repeat (alt_pkg::CAPACITY + 8) @(negedge clk);
		if (bad_results == 0)
			$display("array_list_table_unit regression: pass");
		else
			$display("array_list_table_unit regression: fail");
		$finish;
	end

	// Watchdog
	initial begin
		#8_000_000;
		$display("array_list_table_unit regression: fail");
		$finish;
	end

endmodule
